[rtl/hdwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holonomic drive wheel mixer package
// Shared constants, fixed-point scalings and beat types for the mixer.
// ----------------------------------------------------------------------------
package hdwm_pkg;

    // Angle and fixed-point formats.
    localparam int ANGLE_BITS    = 12;
    localparam int FRACTION_BITS = 14;
    localparam int QUAD_BITS     = ANGLE_BITS - 2;

    // Phase offsets of one eighth and three eighths of a turn.
    localparam logic [ANGLE_BITS-1:0] EIGHTH       = {3'b001, {(ANGLE_BITS-3){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] THREE_EIGHTH = {3'b011, {(ANGLE_BITS-3){1'b0}}};

    // Q30 constants.
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [30:0] SQRT2_Q30   = 31'd1518500250;

    // Series steps of the quarter-wave cosine: divisors 132, 90, 56, 30, 12, 2.
    // Each division is a multiply by a rounded-up reciprocal with 32 + SH bits.
    localparam int COS_STEPS = 6;
    localparam int COS_SH [COS_STEPS] = '{8, 7, 6, 5, 4, 1};
    localparam logic [32:0] COS_REC [COS_STEPS] = '{
        33'(((64'd1 << 40) + 64'd131) / 64'd132),
        33'(((64'd1 << 39) + 64'd89) / 64'd90),
        33'(((64'd1 << 38) + 64'd55) / 64'd56),
        33'(((64'd1 << 37) + 64'd29) / 64'd30),
        33'(((64'd1 << 36) + 64'd11) / 64'd12),
        33'(((64'd1 << 33) + 64'd1) / 64'd2)
    };

    // Pipeline depths.
    localparam int COS_LAT  = 3 + 2 * COS_STEPS + 1;
    localparam int MIX_LAT  = 10;
    localparam int QUO_BITS = 16;
    localparam int PIPE_LAT = COS_LAT + MIX_LAT + QUO_BITS + 1;

    // Divider widths.
    localparam int NUM_W = 50;
    localparam int DEN_W = 34;

    // Command beat.
    typedef struct packed {
        logic [11:0]        heading;
        logic signed [15:0] turn_rate;
        logic [14:0]        drive_power;
    } t_cmd;

    // Result beat.
    typedef struct packed {
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] back_left_speed;
        logic signed [15:0] back_right_speed;
        logic               all_stopped;
    } t_res;

endpackage

[rtl/hdwm_cos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined cosine
// Folds the phase onto a quarter wave and evaluates the Q30 series, at most one
// multiply per stage.
// ----------------------------------------------------------------------------
module hdwm_cos (
    input  logic                            i_clk,
    input  logic [hdwm_pkg::ANGLE_BITS-1:0] i_phase,
    output logic signed [31:0]              o_cos
);
    import hdwm_pkg::*;

    typedef struct packed {
        logic [31:0] x2;
        logic [31:0] val;
        logic        neg;
    } t_cstg;

    logic [QUAD_BITS-1:0]  w_f;
    logic [1:0]            w_quad;
    logic [QUAD_BITS:0]    r_u;
    logic                  r_neg0;
    logic [QUAD_BITS+31:0] w_xp;
    logic [30:0]           r_x;
    logic                  r_neg1;
    logic [61:0]           w_x2p;
    t_cstg                 r_st  [COS_STEPS+1];
    t_cstg                 r_mid [COS_STEPS];
    logic signed [31:0]    r_cos;

    // Quadrant folding: odd quadrants use the complement of the fraction.
    assign w_f    = i_phase[QUAD_BITS-1:0];
    assign w_quad = i_phase[ANGLE_BITS-1 -: 2];

    always_ff @(posedge i_clk) begin
        r_u    <= w_quad[0] ? ({1'b1, {QUAD_BITS{1'b0}}} - {1'b0, w_f}) : {1'b0, w_f};
        r_neg0 <= w_quad[0] ^ w_quad[1];
    end

    // Angle in Q30 radians.
    assign w_xp = (QUAD_BITS + 32)'(r_u) * (QUAD_BITS + 32)'(PI_HALF_Q30);

    always_ff @(posedge i_clk) begin
        r_x    <= 31'(w_xp >> QUAD_BITS);
        r_neg1 <= r_neg0;
    end

    // Square of the angle.
    assign w_x2p = 62'(r_x) * 62'(r_x);

    always_ff @(posedge i_clk) begin
        r_st[0].x2  <= 32'(w_x2p >> 30);
        r_st[0].val <= 32'(Q30_ONE);
        r_st[0].neg <= r_neg1;
    end

    // Series steps, two stages each: product with x2, then constant division and subtraction from one.
    for (genvar i = 0; i < COS_STEPS; i++) begin : g_step
        logic [63:0] w_np;
        logic [65:0] w_tp;
        logic [31:0] w_t;

        assign w_np = 64'(r_st[i].x2) * 64'(r_st[i].val);

        always_ff @(posedge i_clk) begin
            r_mid[i].x2  <= r_st[i].x2;
            r_mid[i].val <= 32'(w_np >> 30);
            r_mid[i].neg <= r_st[i].neg;
        end

        assign w_tp = 66'(r_mid[i].val) * 66'(COS_REC[i]);
        assign w_t  = 32'(w_tp >> (32 + COS_SH[i]));

        always_ff @(posedge i_clk) begin
            r_st[i+1].x2  <= r_mid[i].x2;
            r_st[i+1].val <= (w_t >= 32'(Q30_ONE)) ? 32'd0 : 32'(Q30_ONE) - w_t;
            r_st[i+1].neg <= r_mid[i].neg;
        end
    end

    // Sign from the quadrant.
    always_ff @(posedge i_clk) begin
        r_cos <= r_st[COS_STEPS].neg ? -$signed(r_st[COS_STEPS].val)
                                     : $signed(r_st[COS_STEPS].val);
    end

    assign o_cos = r_cos;

endmodule

[rtl/hdwm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, for quotients known to fit
// in QUO_BITS bits.
// ----------------------------------------------------------------------------
module hdwm_div (
    input  logic                          i_clk,
    input  logic [hdwm_pkg::NUM_W-1:0]    i_num,
    input  logic [hdwm_pkg::DEN_W-1:0]    i_den,
    output logic [hdwm_pkg::QUO_BITS-1:0] o_quo
);
    import hdwm_pkg::*;

    logic [NUM_W-1:0]    r_rem [QUO_BITS];
    logic [DEN_W-1:0]    r_den [QUO_BITS];
    logic [QUO_BITS-1:0] r_q   [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_bit
        logic [NUM_W-1:0]    w_rem;
        logic [DEN_W-1:0]    w_den;
        logic [QUO_BITS-1:0] w_q;
        logic [NUM_W-1:0]    w_sh;
        logic                w_ge;

        if (k == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_q   = r_q[k-1];
        end

        // Trial subtraction of the shifted divisor.
        assign w_sh = NUM_W'(w_den) << (QUO_BITS - 1 - k);
        assign w_ge = (w_rem >= w_sh);

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? (w_rem - w_sh) : w_rem;
            r_den[k] <= w_den;
            r_q[k]   <= {w_q[QUO_BITS-2:0], w_ge};
        end
    end

    assign o_quo = r_q[QUO_BITS-1];

endmodule

[rtl/holonomic_drive_wheel_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holonomic drive wheel mixer
// Throughput: one command per cycle; busy is never raised and results never wait.
// The datapath runs through the 16-stage cosine unit, the ten mixing and scaling
// stages, the 16-stage quotient pipeline and the output register.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module holonomic_drive_wheel_mixer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  hdwm_pkg::t_cmd   i_cmd,
    output logic             o_strobe,
    output hdwm_pkg::t_res   o_res
);
    import hdwm_pkg::*;

    typedef struct packed {
        logic signed [15:0] rot;
        logic [14:0]        pwr;
    } t_side;

    typedef struct packed {
        logic [3:0] neg;
        logic       stop;
        logic       mzero;
    } t_tail;

    localparam logic signed [15:0] ROT_MAX = 16'(2 ** FRACTION_BITS);
    localparam logic signed [15:0] ROT_MIN = -ROT_MAX;
    localparam logic signed [63:0] BIAS30  = 64'sd1073741823;

    logic                  w_acc;
    logic [PIPE_LAT-1:0]   r_vld;
    t_side                 w_side;
    t_side                 r_side [COS_LAT];
    logic signed [31:0]    w_c1;
    logic signed [31:0]    w_c2;

    logic signed [63:0]    r_pr1, r_pr2;
    logic [30:0]           r_m1, r_m2;
    logic signed [31:0]    r_rot1, r_rot2, r_rot3, r_rot4;
    logic [14:0]           r_pwr1, r_pwr2, r_pwr3, r_pwr4, r_pwr5, r_pwr6, r_pwr7, r_pwr8;
    logic signed [31:0]    w_rot30;
    logic signed [32:0]    r_t1, r_t2;
    logic signed [63:0]    r_pm1, r_pm2;
    logic signed [63:0]    w_q1, w_q2;
    logic signed [32:0]    r_p1, r_p2;
    logic signed [33:0]    r_v   [4];
    logic [32:0]           r_abs6 [4];
    logic [32:0]           r_abs7 [4];
    logic [32:0]           r_abs8 [4];
    logic [3:0]            r_neg6, r_neg7, r_neg8, r_neg9;
    logic [32:0]           r_mx01, r_mx23, r_mx8, r_mx9;
    logic [47:0]           r_prod [4];
    logic                  r_stop9;
    logic [NUM_W-1:0]      r_num [4];
    logic [DEN_W-1:0]      r_den;
    t_tail                 r_tail10;
    t_tail                 r_tail [QUO_BITS];
    logic [QUO_BITS-1:0]   w_quo [4];
    logic signed [15:0]    w_spd [4];
    t_res                  r_res;

    // Commands are never held off.
    assign o_busy = 1'b0;
    assign w_acc  = i_start & ~o_busy;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_acc};
        end
    end

    // Clamped rotation and power wait for the cosine results.
    always_comb begin
        w_side.pwr = i_cmd.drive_power;
        if (i_cmd.turn_rate > ROT_MAX) begin
            w_side.rot = ROT_MAX;
        end else if (i_cmd.turn_rate < ROT_MIN) begin
            w_side.rot = ROT_MIN;
        end else begin
            w_side.rot = i_cmd.turn_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= w_side;
        for (int i = 1; i < COS_LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Cosines at heading plus one and three eighths of a turn.
    hdwm_cos u_cos1 (
        .i_clk   (i_clk),
        .i_phase (i_cmd.heading[ANGLE_BITS-1:0] + EIGHTH),
        .o_cos   (w_c1)
    );

    hdwm_cos u_cos2 (
        .i_clk   (i_clk),
        .i_phase (i_cmd.heading[ANGLE_BITS-1:0] + THREE_EIGHTH),
        .o_cos   (w_c2)
    );

    // Stage 1: sqrt2 products and translation weight.
    assign w_rot30 = 32'(r_side[COS_LAT-1].rot) <<< (30 - FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        r_pr1  <= 64'(w_c1) * 64'(signed'({1'b0, SQRT2_Q30}));
        r_pr2  <= 64'(w_c2) * 64'(signed'({1'b0, SQRT2_Q30}));
        r_m1   <= Q30_ONE - ((w_rot30 < 0) ? 31'(-w_rot30) : 31'(w_rot30));
        r_rot1 <= w_rot30;
        r_pwr1 <= r_side[COS_LAT-1].pwr;
    end

    // Stage 2: scale back to Q30, truncating toward zero.
    always_ff @(posedge i_clk) begin
        r_t1   <= 33'((r_pr1 + ((r_pr1 < 0) ? BIAS30 : 64'sd0)) >>> 30);
        r_t2   <= 33'((r_pr2 + ((r_pr2 < 0) ? BIAS30 : 64'sd0)) >>> 30);
        r_m2   <= r_m1;
        r_rot2 <= r_rot1;
        r_pwr2 <= r_pwr1;
    end

    // Stage 3: weight by one minus the rotation magnitude.
    always_ff @(posedge i_clk) begin
        r_pm1  <= 64'(r_t1) * 64'(signed'({1'b0, r_m2}));
        r_pm2  <= 64'(r_t2) * 64'(signed'({1'b0, r_m2}));
        r_rot3 <= r_rot2;
        r_pwr3 <= r_pwr2;
    end

    // Stage 4: negated translation terms.
    assign w_q1 = (r_pm1 + ((r_pm1 < 0) ? BIAS30 : 64'sd0)) >>> 30;
    assign w_q2 = (r_pm2 + ((r_pm2 < 0) ? BIAS30 : 64'sd0)) >>> 30;

    always_ff @(posedge i_clk) begin
        r_p1   <= -33'(w_q1);
        r_p2   <= -33'(w_q2);
        r_rot4 <= r_rot3;
        r_pwr4 <= r_pwr3;
    end

    // Stage 5: per-wheel sums.
    always_ff @(posedge i_clk) begin
        r_v[0] <= 34'(r_p2) + 34'(r_rot4);
        r_v[1] <= 34'(r_p1) - 34'(r_rot4);
        r_v[2] <= 34'(r_p1) + 34'(r_rot4);
        r_v[3] <= 34'(r_p2) - 34'(r_rot4);
        r_pwr5 <= r_pwr4;
    end

    // Stage 6: magnitudes and signs.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_abs6[k] <= r_v[k][33] ? 33'(-r_v[k]) : 33'(r_v[k]);
            r_neg6[k] <= r_v[k][33];
        end
        r_pwr6 <= r_pwr5;
    end

    // Stages 7 and 8: largest magnitude over the four wheels.
    always_ff @(posedge i_clk) begin
        r_mx01 <= (r_abs6[0] > r_abs6[1]) ? r_abs6[0] : r_abs6[1];
        r_mx23 <= (r_abs6[2] > r_abs6[3]) ? r_abs6[2] : r_abs6[3];
        r_abs7 <= r_abs6;
        r_neg7 <= r_neg6;
        r_pwr7 <= r_pwr6;
    end

    always_ff @(posedge i_clk) begin
        r_mx8  <= (r_mx01 > r_mx23) ? r_mx01 : r_mx23;
        r_abs8 <= r_abs7;
        r_neg8 <= r_neg7;
        r_pwr8 <= r_pwr7;
    end

    // Stage 9: magnitude times power.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= 48'(r_abs8[k]) * 48'(r_pwr8);
        end
        r_mx9   <= r_mx8;
        r_neg9  <= r_neg8;
        r_stop9 <= (r_pwr8 == 15'd0);
    end

    // Stage 10: rounding numerator and doubled divisor.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_num[k] <= {1'b0, r_prod[k], 1'b0} + NUM_W'(r_mx9);
        end
        r_den          <= {r_mx9, 1'b0};
        r_tail10.neg   <= r_neg9;
        r_tail10.stop  <= r_stop9;
        r_tail10.mzero <= (r_mx9 == 33'd0);
    end

    // Quotient lanes, one per wheel.
    for (genvar k = 0; k < 4; k++) begin : g_lane
        hdwm_div u_div (
            .i_clk (i_clk),
            .i_num (r_num[k]),
            .i_den (r_den),
            .o_quo (w_quo[k])
        );
        assign w_spd[k] = r_tail[QUO_BITS-1].neg[k] ? -$signed(w_quo[k])
                                                     : $signed(w_quo[k]);
    end

    always_ff @(posedge i_clk) begin
        r_tail[0] <= r_tail10;
        for (int i = 1; i < QUO_BITS; i++) begin
            r_tail[i] <= r_tail[i-1];
        end
    end

    // Output register: zero speeds on stop or when every wheel term is zero.
    always_ff @(posedge i_clk) begin
        if (r_tail[QUO_BITS-1].stop || r_tail[QUO_BITS-1].mzero) begin
            r_res.front_left_speed  <= '0;
            r_res.front_right_speed <= '0;
            r_res.back_left_speed   <= '0;
            r_res.back_right_speed  <= '0;
        end else begin
            r_res.front_left_speed  <= w_spd[0];
            r_res.front_right_speed <= w_spd[1];
            r_res.back_left_speed   <= w_spd[2];
            r_res.back_right_speed  <= w_spd[3];
        end
        r_res.all_stopped <= r_tail[QUO_BITS-1].stop;
    end

    assign o_strobe = r_vld[PIPE_LAT-1];
    assign o_res    = r_res;

endmodule

[rtl/hdwm_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixer port checker
// Watches the mixer ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module hdwm_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input hdwm_pkg::t_cmd i_cmd,
    input logic           o_strobe,
    input hdwm_pkg::t_res o_res
);
    import hdwm_pkg::*;

    // The mixer never holds a command off.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("mixer raised busy");

    // No result beat at the edge where reset is released.
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_strobe)
        else $error("result beat right after reset");

    // A stop result carries zero speeds on all wheels.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.all_stopped) |->
            (o_res.front_left_speed == 16'sd0 && o_res.front_right_speed == 16'sd0 &&
             o_res.back_left_speed == 16'sd0 && o_res.back_right_speed == 16'sd0))
        else $error("stopped result with non-zero speed");

    // A command with zero power yields a stop result beat.
    a_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.drive_power == 15'd0) |->
            ##PIPE_LAT (o_strobe && o_res.all_stopped))
        else $error("zero-power command did not stop the wheels");

endmodule

bind holonomic_drive_wheel_mixer hdwm_chk u_hdwm_chk (.*);
